[hdl/ccd_pkg.sv]
// shared types, codes and helpers for the 3-cnf clause decimator
// no dependencies; used by ccd_store, ccd_eval and cnf_clause_decimator_core

package ccd_pkg;

	// field widths
	localparam int LIT_W = 13;
	localparam int CNT_W = 16;
	localparam int VAR_W = 12;
	localparam int K     = 3;

	// parameter defaults
	localparam int VARIABLES_DEF   = 4096;
	localparam int MAX_CLAUSES_DEF = 65536;

	// largest reportable variable magnitude
	localparam logic [VAR_W-1:0] VAR_LIMIT = {VAR_W{1'b1}};

	// request kinds
	localparam logic REQ_ASSIGN = 1'b0;
	localparam logic REQ_CLAUSE = 1'b1;

	// clause status codes
	localparam logic [1:0] ST_OPEN  = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_UNSAT = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// assignment store codes
	localparam logic [1:0] VAL_UNSET = 2'd0;
	localparam logic [1:0] VAL_TRUE  = 2'd1;
	localparam logic [1:0] VAL_FALSE = 2'd2;

	typedef logic signed [LIT_W-1:0] lit_t;
	typedef logic [LIT_W-1:0]        mag_t;
	typedef logic [1:0]              val_t;

	// evaluation result of one clause
	typedef struct packed {
		logic [1:0]       status;
		lit_t             lit_a;
		lit_t             lit_b;
		lit_t             lit_c;
		logic [1:0]       remaining;
		logic [VAR_W-1:0] open_max;
	} eval_t;

	// unsigned magnitude of a literal, -4096 gives 4096
	function automatic mag_t lit_mag(input lit_t lit);
		mag_t m;
		m = lit[LIT_W-1] ? mag_t'(~lit + 1'b1) : mag_t'(lit);
		return m;
	endfunction

endpackage

[hdl/ccd_store.sv]
// assignment store: three copies written together, one lookup port each
// clears itself after reset; depends on ccd_pkg

module ccd_store #(
	parameter int VARIABLES = ccd_pkg::VARIABLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             busy,
	input  logic             wr_en,
	input  ccd_pkg::mag_t    wr_mag,
	input  ccd_pkg::val_t    wr_val,
	input  logic             rd_en,
	input  ccd_pkg::mag_t    rd_mag   [ccd_pkg::K],
	output ccd_pkg::val_t    rd_state [ccd_pkg::K]
);

	localparam int AW = $clog2(VARIABLES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(VARIABLES - 1);

	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;
	logic          wr_in_range;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	ccd_pkg::val_t mem_data;

	// clearing pass over every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	assign busy = clr_active_q;

	// variables beyond the store are never written
	assign wr_in_range = 32'(wr_mag) < VARIABLES;

	// write port shared by clearing and assign beats
	always_comb begin
		mem_we   = clr_active_q || (wr_en && wr_in_range);
		mem_addr = clr_active_q ? clr_addr_q : AW'(wr_mag);
		mem_data = clr_active_q ? ccd_pkg::VAL_UNSET : wr_val;
	end

	// one copy per clause literal
	for (genvar g = 0; g < ccd_pkg::K; g++) begin : g_copy
		ccd_pkg::val_t mem [VARIABLES];
		ccd_pkg::val_t rd_data_s1;
		logic          rd_range_s1;

		always_ff @(posedge clk) begin
			if (mem_we) begin
				mem[mem_addr] <= mem_data;
			end
			if (rd_en) begin
				rd_data_s1  <= mem[AW'(rd_mag[g])];
				rd_range_s1 <= 32'(rd_mag[g]) < VARIABLES;
			end
		end

		// out-of-range variables read unset
		assign rd_state[g] = rd_range_s1 ? rd_data_s1 : ccd_pkg::VAL_UNSET;
	end

endmodule

[hdl/ccd_eval.sv]
// clause evaluator: scans up to three literals against their looked-up values
// pure combinational; depends on ccd_pkg

module ccd_eval (
	input  ccd_pkg::lit_t  lit   [ccd_pkg::K],
	input  ccd_pkg::val_t  state [ccd_pkg::K],
	output ccd_pkg::eval_t res
);

	logic [ccd_pkg::K-1:0] act;
	logic [1:0]            status;
	logic [1:0]            left;
	ccd_pkg::lit_t         kept [ccd_pkg::K];
	ccd_pkg::val_t         want [ccd_pkg::K];
	ccd_pkg::mag_t         mag  [ccd_pkg::K];
	logic [ccd_pkg::VAR_W-1:0] mag_sat [ccd_pkg::K];
	logic [ccd_pkg::VAR_W-1:0] max_ab;
	logic [ccd_pkg::VAR_W-1:0] max_abc;

	// clause ends at the first zero literal
	always_comb begin
		act[0] = lit[0] != '0;
		act[1] = act[0] && (lit[1] != '0);
		act[2] = act[1] && (lit[2] != '0);
	end

	// in-order scan: agreement satisfies, conflict removes
	always_comb begin
		status = act[0] ? ccd_pkg::ST_OPEN : ccd_pkg::ST_EMPTY;
		left   = 2'(act[0]) + 2'(act[1]) + 2'(act[2]);
		for (int k = 0; k < ccd_pkg::K; k++) begin
			kept[k] = '0;
			want[k] = lit[k][ccd_pkg::LIT_W-1] ? ccd_pkg::VAL_FALSE : ccd_pkg::VAL_TRUE;
		end
		for (int k = 0; k < ccd_pkg::K; k++) begin
			if (act[k] && (status == ccd_pkg::ST_OPEN)) begin
				if (state[k] == want[k]) begin
					status = ccd_pkg::ST_SAT;
				end else if (state[k] != ccd_pkg::VAL_UNSET) begin
					left = left - 2'd1;
					if (left == 2'd0) begin
						status = ccd_pkg::ST_UNSAT;
					end
				end else begin
					kept[k] = lit[k];
				end
			end
		end
	end

	// largest kept magnitude, clipped to the output range
	always_comb begin
		for (int k = 0; k < ccd_pkg::K; k++) begin
			mag[k]     = ccd_pkg::lit_mag(kept[k]);
			mag_sat[k] = (mag[k] > ccd_pkg::mag_t'(ccd_pkg::VAR_LIMIT)) ?
				ccd_pkg::VAR_LIMIT : mag[k][ccd_pkg::VAR_W-1:0];
		end
		max_ab  = (mag_sat[0] > mag_sat[1]) ? mag_sat[0] : mag_sat[1];
		max_abc = (max_ab > mag_sat[2]) ? max_ab : mag_sat[2];
	end

	// closed clauses give no literals
	always_comb begin
		res.status = status;
		if (status == ccd_pkg::ST_OPEN) begin
			res.lit_a     = kept[0];
			res.lit_b     = kept[1];
			res.lit_c     = kept[2];
			res.remaining = left;
			res.open_max  = max_abc;
		end else begin
			res.lit_a     = '0;
			res.lit_b     = '0;
			res.lit_c     = '0;
			res.remaining = 2'd0;
			res.open_max  = '0;
		end
	end

endmodule

[hdl/cnf_clause_decimator_core.sv]
// 3-cnf clause decimator: assignment store lookups, clause reduction, running totals
// clause beats pass through stage 1 (store lookups) and then the output register
// one beat per cycle unless stalled; the three lookups use one store copy each
// assign beats write the store at acceptance and give no output beat
// reset: totals clear at once; the store then clears every entry with tready low
// depends on ccd_pkg, ccd_store and ccd_eval

module cnf_clause_decimator_core #(
	parameter int VARIABLES   = ccd_pkg::VARIABLES_DEF,
	parameter int MAX_CLAUSES = ccd_pkg::MAX_CLAUSES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// assign_lit[12:0], lit_a[25:13], lit_b[38:26], lit_c[51:39], zero[55:52]
	input  logic [55:0]  s_axis_tdata,
	// req_type[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// clause_status[1:0], out_lit_a[14:2], out_lit_b[27:15], out_lit_c[40:28],
	// remaining[42:41], total_satisfied[58:43], total_unsat[74:59],
	// total_open[90:75], largest_open_var[102:91], zero[103]
	output logic [103:0] m_axis_tdata
);

	localparam logic [ccd_pkg::CNT_W-1:0] CNT_LIMIT =
		ccd_pkg::CNT_W'((MAX_CLAUSES - 1 < 65535) ? MAX_CLAUSES - 1 : 65535);

	logic          busy;
	logic          s_accept;
	logic          adv;
	logic          is_clause;
	ccd_pkg::lit_t in_lit  [ccd_pkg::K];
	ccd_pkg::mag_t in_mag  [ccd_pkg::K];
	ccd_pkg::lit_t assign_lit;
	ccd_pkg::val_t state   [ccd_pkg::K];
	ccd_pkg::eval_t ev;

	logic          valid_s1;
	ccd_pkg::lit_t lit_s1 [ccd_pkg::K];

	logic [ccd_pkg::CNT_W-1:0] sat_q, unsat_q, open_q;
	logic [ccd_pkg::VAR_W-1:0] max_q;
	logic [ccd_pkg::CNT_W-1:0] sat_nxt, unsat_nxt, open_nxt;
	logic [ccd_pkg::VAR_W-1:0] max_nxt;

	logic                      out_valid_q;
	ccd_pkg::eval_t            out_ev_q;
	logic [ccd_pkg::CNT_W-1:0] out_sat_q, out_unsat_q, out_open_q;
	logic [ccd_pkg::VAR_W-1:0] out_max_q;

	// input beat unpacking
	always_comb begin
		assign_lit = s_axis_tdata[12:0];
		in_lit[0]  = s_axis_tdata[25:13];
		in_lit[1]  = s_axis_tdata[38:26];
		in_lit[2]  = s_axis_tdata[51:39];
		for (int k = 0; k < ccd_pkg::K; k++) begin
			in_mag[k] = ccd_pkg::lit_mag(in_lit[k]);
		end
	end

	// handshake: stage 1 moves on when the output register is free
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !busy && (!valid_s1 || adv);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign is_clause     = s_axis_tuser == ccd_pkg::REQ_CLAUSE;

	ccd_store #(
		.VARIABLES (VARIABLES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.busy     (busy),
		.wr_en    (s_accept && !is_clause && (assign_lit != '0)),
		.wr_mag   (ccd_pkg::lit_mag(assign_lit)),
		.wr_val   (assign_lit[ccd_pkg::LIT_W-1] ? ccd_pkg::VAL_FALSE : ccd_pkg::VAL_TRUE),
		.rd_en    (s_accept && is_clause),
		.rd_mag   (in_mag),
		.rd_state (state)
	);

	// stage 1 valid holds clause beats only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= is_clause;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 literals, loaded alongside the store lookups
	always_ff @(posedge clk) begin
		if (s_accept && is_clause) begin
			for (int k = 0; k < ccd_pkg::K; k++) begin
				lit_s1[k] <= in_lit[k];
			end
		end
	end

	ccd_eval u_eval (
		.lit   (lit_s1),
		.state (state),
		.res   (ev)
	);

	// saturating totals after this clause
	always_comb begin
		sat_nxt   = sat_q;
		unsat_nxt = unsat_q;
		open_nxt  = open_q;
		max_nxt   = max_q;
		case (ev.status)
			ccd_pkg::ST_OPEN: begin
				if (open_q < CNT_LIMIT) open_nxt = open_q + 1'b1;
				if (ev.open_max > max_q) max_nxt = ev.open_max;
			end
			ccd_pkg::ST_UNSAT: begin
				if (unsat_q < CNT_LIMIT) unsat_nxt = unsat_q + 1'b1;
			end
			ccd_pkg::ST_SAT, ccd_pkg::ST_EMPTY: begin
				if (sat_q < CNT_LIMIT) sat_nxt = sat_q + 1'b1;
			end
			default: begin
				sat_nxt = sat_q;
			end
		endcase
	end

	// totals and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q       <= '0;
			unsat_q     <= '0;
			open_q      <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				sat_q   <= sat_nxt;
				unsat_q <= unsat_nxt;
				open_q  <= open_nxt;
				max_q   <= max_nxt;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_ev_q    <= ev;
			out_sat_q   <= sat_nxt;
			out_unsat_q <= unsat_nxt;
			out_open_q  <= open_nxt;
			out_max_q   <= max_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_max_q, out_open_q, out_unsat_q, out_sat_q,
		out_ev_q.remaining, out_ev_q.lit_c, out_ev_q.lit_b, out_ev_q.lit_a, out_ev_q.status};

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for cnf_clause_decimator_core: assign and clause beats in,
// clause results checked field by field against a scoreboard that tracks the store
// depends on ccd_pkg and cnf_clause_decimator_core

module testbench;
	import ccd_pkg::*;

	localparam int COUNT_LIMIT = (MAX_CLAUSES_DEF - 1 < 65535) ? MAX_CLAUSES_DEF - 1 : 65535;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX  = 10;

	// one clause result as the block should give it
	typedef struct {
		logic [1:0]       status;
		lit_t             lit_a;
		lit_t             lit_b;
		lit_t             lit_c;
		logic [1:0]       remaining;
		logic [CNT_W-1:0] n_sat;
		logic [CNT_W-1:0] n_unsat;
		logic [CNT_W-1:0] n_open;
		logic [VAR_W-1:0] max_var;
	} clause_result_t;

	// scoreboard: own copy of the assignment store and totals, queue of clause results due
	class clause_scoreboard;
		val_t           store [VARIABLES_DEF];
		int             n_sat, n_unsat, n_open, max_var;
		clause_result_t pending_results [$];
		int             mismatches, checked, assigns, clauses;
		int             status_seen [4];

		function new();
			foreach (store[i])
				store[i] = VAL_UNSET;
			n_sat = 0;
			n_unsat = 0;
			n_open = 0;
			max_var = 0;
			mismatches = 0;
			checked = 0;
			assigns = 0;
			clauses = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		static function int var_index(lit_t lit);
			int v;
			v = lit;
			return (v < 0) ? -v : v;
		endfunction

		// note an accepted beat: assigns update the store, clauses queue a result
		function void take_request(logic req, lit_t assign_lit, lit_t a, lit_t b, lit_t c);
			clause_result_t r;
			lit_t           lits [K];
			lit_t           kept [K];
			int             n, left, m, k;
			val_t           s, want;
			if (req == REQ_ASSIGN) begin
				assigns++;
				m = var_index(assign_lit);
				if (assign_lit != 0 && m < VARIABLES_DEF)
					store[m] = (assign_lit > 0) ? VAL_TRUE : VAL_FALSE;
				return;
			end
			clauses++;
			lits[0] = a;
			lits[1] = b;
			lits[2] = c;
			foreach (kept[i])
				kept[i] = '0;
			// clause ends at the first absent literal
			n = 0;
			while (n < K && lits[n] != 0)
				n++;
			left = n;
			r.status = (n == 0) ? ST_EMPTY : ST_OPEN;
			// scan in order: agreement satisfies, disagreement removes
			for (k = 0; k < n && r.status == ST_OPEN; k++) begin
				m = var_index(lits[k]);
				s = (m < VARIABLES_DEF) ? store[m] : VAL_UNSET;
				want = (lits[k] > 0) ? VAL_TRUE : VAL_FALSE;
				if (s == want)
					r.status = ST_SAT;
				else if (s != VAL_UNSET) begin
					left--;
					if (left == 0)
						r.status = ST_UNSAT;
				end else
					kept[k] = lits[k];
			end
			// saturating totals and largest open variable
			if (r.status == ST_OPEN) begin
				if (n_open < COUNT_LIMIT)
					n_open++;
				for (k = 0; k < K; k++) begin
					m = var_index(kept[k]);
					if (m > VAR_LIMIT)
						m = VAR_LIMIT;
					if (m > max_var)
						max_var = m;
				end
			end else begin
				foreach (kept[i])
					kept[i] = '0;
				left = 0;
				if (r.status == ST_UNSAT) begin
					if (n_unsat < COUNT_LIMIT)
						n_unsat++;
				end else if (n_sat < COUNT_LIMIT)
					n_sat++;
			end
			r.lit_a = kept[0];
			r.lit_b = kept[1];
			r.lit_c = kept[2];
			r.remaining = left[1:0];
			r.n_sat = n_sat[CNT_W-1:0];
			r.n_unsat = n_unsat[CNT_W-1:0];
			r.n_open = n_open[CNT_W-1:0];
			r.max_var = max_var[VAR_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%t: %s of clause result %0d: expected %0d, got %0d",
						$time, name, checked, exp_v, act_v);
			end
		endfunction

		// compare one output beat with the oldest result due
		function void check_beat(logic [103:0] d);
			clause_result_t want_r;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%t: output beat with no clause pending: %h", $time, d);
				return;
			end
			want_r = pending_results.pop_front();
			status_seen[want_r.status]++;
			compare_field("clause_status",    want_r.status,         d[1:0]);
			compare_field("out_lit_a",        int'(want_r.lit_a),    int'(lit_t'(d[14:2])));
			compare_field("out_lit_b",        int'(want_r.lit_b),    int'(lit_t'(d[27:15])));
			compare_field("out_lit_c",        int'(want_r.lit_c),    int'(lit_t'(d[40:28])));
			compare_field("remaining",        want_r.remaining,      d[42:41]);
			compare_field("total_satisfied",  want_r.n_sat,          d[58:43]);
			compare_field("total_unsat",      want_r.n_unsat,        d[74:59]);
			compare_field("total_open",       want_r.n_open,         d[90:75]);
			compare_field("largest_open_var", want_r.max_var,        d[102:91]);
			checked++;
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;

	clause_scoreboard sb = new();
	int send_idle_pct = 27;
	int recv_idle_pct = 85;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	cnf_clause_decimator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result beats checked at the rising edge
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata);
	end

	// offer one beat, entered and left at a falling edge
	task automatic send_beat(input logic req, input lit_t assign_lit,
			input lit_t a, input lit_t b, input lit_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {4'b0, c, b, a, assign_lit};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_request(req, assign_lit, a, b, c);
		@(negedge clk);
	endtask

	// unused fields carry noise
	task automatic assign_var(input lit_t lit);
		send_beat(REQ_ASSIGN, lit, lit_t'($urandom), lit_t'($urandom), lit_t'($urandom));
	endtask

	task automatic send_clause(input lit_t a, input lit_t b, input lit_t c);
		send_beat(REQ_CLAUSE, lit_t'($urandom), a, b, c);
	endtask

	// mostly a small pool of variables so clauses hit assignments, some raw patterns
	function automatic lit_t pick_lit();
		int v;
		case ($urandom_range(9))
			0: return lit_t'($urandom);
			1: return '0;
			default: begin
				v = $urandom_range(24, 1);
				return $urandom_range(1) ? lit_t'(v) : lit_t'(-v);
			end
		endcase
	endfunction

	task automatic run_random(input int count, input int tx_idle, input int rx_idle);
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		repeat (count) begin
			if ($urandom_range(99) < 40)
				assign_var(pick_lit());
			else
				send_clause(pick_lit(), pick_lit(), pick_lit());
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty clauses, literals past a zero, out-of-range variable
		send_clause(0, 0, 0);
		send_clause(0, 5, -7);
		send_clause(4095, -4096, 1);
		// ignored assigns, reassignment, sign extremes
		assign_var(0);
		assign_var(-4096);
		assign_var(4095);
		assign_var(-4095);
		assign_var(1);
		assign_var(-2);
		assign_var(3);
		// unsat, satisfied and partly reduced clauses
		send_clause(-1, 2, -3);
		send_clause(-1, -2, 0);
		send_clause(-1, 5, -3);
		send_clause(4095, 0, 9);
		send_clause(-4095, 1, 0);
		send_clause(-4096, -4096, -4096);
		send_clause(6, 0, -1);
		send_clause(2, -6, -4096);
		assign_var(4095);
		send_clause(-4095, 0, 0);
		send_clause(1, 0, 0);
		send_clause(-3, -1, 4095);

		// random mix over three idling profiles, long receiver hold-off in the last
		run_random(480, 27, 85);
		run_random(480, 85, 27);
		hold_request = 1'b1;
		run_random(490, 0, 0);
		s_axis_tvalid <= 1'b0;

		// drain, then watch for stray beats
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.pending_results.size() != 0)
			$display("%0d clause results never arrived", sb.pending_results.size());
		$display("%0d beats sent (%0d assigns, %0d clauses), %0d clause results checked",
			sb.assigns + sb.clauses, sb.assigns, sb.clauses, sb.checked);
		$display("results: %0d open, %0d satisfied, %0d unsat, %0d empty",
			sb.status_seen[ST_OPEN], sb.status_seen[ST_SAT], sb.status_seen[ST_UNSAT],
			sb.status_seen[ST_EMPTY]);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#(20_000_000);
		$display("timeout: %0d clause results outstanding", sb.pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
